// ----- rtl/xtea_variant_block_encrypt_macros.svh -----
// Assertion macros for the RTL files of the XTEA-variant block encryptor.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef XTEA_VARIANT_BLOCK_ENCRYPT_MACROS_SVH
`define XTEA_VARIANT_BLOCK_ENCRYPT_MACROS_SVH
`ifndef SYNTHESIS
`define XVE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xve assertion failed");
`define XVE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("xve forbidden condition seen");
`else
`define XVE_ASSERT(label, clk, rst_n, prop)
`define XVE_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/xve_pkg.sv -----
// Package for the XTEA-variant block encryptor: widths, cipher constants,
// the pipeline stage type and the round helper functions. No dependencies.
package xve_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam int ROUND_COUNT_DEFAULT = 20;

    localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9B73_7699;
    localparam logic [WORD_WIDTH-1:0] KEY_WORD0 = 32'h9382_1DFC;

    localparam logic [0:0] REG_SESSION_KEY = 1'b0;

    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        logic  valid;
        word_t y;
        word_t z;
    } xve_stage_t;

    function automatic word_t mix(input word_t v);
        word_t shifted;
        shifted = (v << 4) ^ (v >> 5);
        return shifted + v;
    endfunction

    function automatic word_t round_sum(input int unsigned r);
        logic [2*WORD_WIDTH-1:0] product;
        product = (2*WORD_WIDTH)'(r) * (2*WORD_WIDTH)'(DELTA);
        return product[WORD_WIDTH-1:0];
    endfunction

endpackage

// ----- rtl/xve_block_if.sv -----
// Request channel interfaces for plaintext blocks and ciphertext blocks.
// Depends on xve_pkg for the word width.
interface xve_block_if;
    import xve_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] block_low;
    logic [WORD_WIDTH-1:0] block_high;

    modport source (output valid, output block_low, output block_high, input ready);
    modport sink (input valid, input block_low, input block_high, output ready);
endinterface

interface xve_cipher_if;
    import xve_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] cipher_low;
    logic [WORD_WIDTH-1:0] cipher_high;

    modport source (output valid, output cipher_low, output cipher_high, input ready);
    modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface

// ----- rtl/xve_apb_regs.sv -----
// APB-style configuration register file holding the session key.
// Depends on xve_pkg for widths and register indexes.
module xve_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [xve_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [xve_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [xve_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output logic [xve_pkg::WORD_WIDTH-1:0]   session_key
);
    import xve_pkg::*;

    logic [0:0]            reg_index;
    logic                  write_en;
    logic [WORD_WIDTH-1:0] session_key_reg;
    logic [WORD_WIDTH-1:0] session_key_next;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_WIDTH-1:2];
    assign write_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        session_key_next = session_key_reg;
        if (write_en && reg_index == REG_SESSION_KEY)
        begin
            session_key_next = pwdata[WORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_key_reg <= '0;
        end
        else
        begin
            session_key_reg <= session_key_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_SESSION_KEY)
        begin
            prdata = PDATA_WIDTH'(session_key_reg);
        end
    end

    assign session_key = session_key_reg;
endmodule

// ----- rtl/xve_round_cell.sv -----
// One half-round cell of the cipher pipeline: updates y or z and passes the block on.
// Depends on xve_pkg and the assertion macros header.
`include "xtea_variant_block_encrypt_macros.svh"
module xve_round_cell #(
    parameter logic [xve_pkg::WORD_WIDTH-1:0] SUM    = '0,
    parameter bit                             HALF_Z = 1'b0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [xve_pkg::WORD_WIDTH-1:0] session_key,
    input  xve_pkg::xve_stage_t            up,
    output logic                           up_ready,
    output xve_pkg::xve_stage_t            down,
    input  logic                           down_ready
);
    import xve_pkg::*;

    // The key table index is (sum & 4) for y and ((sum >> 11) & 4) for z.
    localparam bit USE_SESSION = HALF_Z ? SUM[13] : SUM[2];

    word_t key;
    word_t round_key;
    word_t mixed;
    word_t updated;
    logic  valid_reg;
    logic  valid_next;
    word_t y_reg;
    word_t y_next;
    word_t z_reg;
    word_t z_next;

    assign key       = USE_SESSION ? session_key : KEY_WORD0;
    assign round_key = SUM + key;
    assign mixed     = mix(HALF_Z ? up.y : up.z);
    assign updated   = (HALF_Z ? up.z : up.y) + (mixed ^ round_key);
    assign up_ready  = !valid_reg || down_ready;

    always_comb
    begin
        valid_next = valid_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        if (up_ready)
        begin
            valid_next = up.valid;
            y_next     = HALF_Z ? up.y : updated;
            z_next     = HALF_Z ? updated : up.z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign down.valid = valid_reg;
    assign down.y     = y_reg;
    assign down.z     = z_reg;

    `XVE_ASSERT(a_stall_keeps_request, clk, rst_n, valid_reg && !down_ready |=> valid_reg)
    `XVE_ASSERT(a_stall_keeps_data, clk, rst_n, valid_reg && !down_ready |=> $stable(y_reg) && $stable(z_reg))
    `XVE_ASSERT_NEVER(a_no_take_when_full, clk, rst_n, up_ready && valid_reg && !down_ready)
endmodule

// ----- rtl/xtea_variant_block_encrypt.sv -----
// Top level of the XTEA-variant block encryptor: config registers and a chain of round cells.
// Depends on xve_pkg, xve_block_if, xve_cipher_if, xve_apb_regs and xve_round_cell.
//
//   Channel      Dir   Payload                      Handshake
//   plaintext    in    block_low, block_high        valid / ready
//   ciphertext   out   cipher_low, cipher_high      valid / ready
//   config       in    session_key at address 0     APB psel / penable
//
// One request enters per cycle while the output is not stalled and passes through the chain of
// two half-round cells per round, each one register deep.
// Reset clears every cell's valid flag and sets the session key to zero.
// A cell takes a new request when it is empty or its neighbor takes its own,
// so a stalled output only holds back cells that are already full.
module xtea_variant_block_encrypt #(
    parameter int ROUND_COUNT = xve_pkg::ROUND_COUNT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [xve_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [xve_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [xve_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                            pready,
    xve_block_if.sink                       plaintext,
    xve_cipher_if.source                    ciphertext
);
    import xve_pkg::*;

    localparam int CELLS = 2 * ROUND_COUNT;

    word_t      session_key;
    xve_stage_t chain [0:CELLS];
    logic       chain_ready [0:CELLS];

    xve_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .session_key (session_key)
    );

    assign chain[0].valid  = plaintext.valid;
    assign chain[0].y      = plaintext.block_low;
    assign chain[0].z      = plaintext.block_high;
    assign plaintext.ready = chain_ready[0];

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        xve_round_cell #(
            .SUM    (round_sum(r)),
            .HALF_Z (1'b0)
        ) u_cell_y (
            .clk         (clk),
            .rst_n       (rst_n),
            .session_key (session_key),
            .up          (chain[2*r]),
            .up_ready    (chain_ready[2*r]),
            .down        (chain[2*r+1]),
            .down_ready  (chain_ready[2*r+1])
        );

        xve_round_cell #(
            .SUM    (round_sum(r + 1)),
            .HALF_Z (1'b1)
        ) u_cell_z (
            .clk         (clk),
            .rst_n       (rst_n),
            .session_key (session_key),
            .up          (chain[2*r+1]),
            .up_ready    (chain_ready[2*r+1]),
            .down        (chain[2*r+2]),
            .down_ready  (chain_ready[2*r+2])
        );
    end

    assign chain_ready[CELLS]     = ciphertext.ready;
    assign ciphertext.valid       = chain[CELLS].valid;
    assign ciphertext.cipher_low  = chain[CELLS].y;
    assign ciphertext.cipher_high = chain[CELLS].z;
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for xtea_variant_block_encrypt: random and directed blocks under
// several session keys, with random idling on both channels. Depends on xve_pkg, the
// xve_block_if and xve_cipher_if interfaces and the top level of the block.
module testbench;
    import xve_pkg::*;

    localparam int NUM_ROUNDS = 20;
    localparam int LATENCY = 2 * NUM_ROUNDS + 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int BLOCKS_PER_PHASE = 250;
    localparam int NUM_PHASES = 7;
    localparam logic [PADDR_WIDTH-1:0] SESSION_KEY_ADDR = PADDR_WIDTH'(4 * REG_SESSION_KEY);
    localparam word_t DELTA_STEP = 32'h9B73_7699;
    localparam word_t KEY_FIXED = 32'h9382_1DFC;

    typedef struct packed {
        word_t cipher_low;
        word_t cipher_high;
    } cipher_pair_t;

    class cipher_scoreboard;
        cipher_pair_t pending[$];
        word_t session_key;
        int errors;

        function new();
            session_key = '0;
            errors = 0;
        endfunction

        function word_t feistel_mix(input word_t v);
            return ((v << 4) ^ (v >> 5)) + v;
        endfunction

        function word_t table_word(input word_t idx);
            return ((idx & 32'd4) != 0) ? session_key : KEY_FIXED;
        endfunction

        function cipher_pair_t encipher_block(input word_t lo, input word_t hi);
            word_t y;
            word_t z;
            word_t sum;
            int r;
            cipher_pair_t res;
            y = lo;
            z = hi;
            sum = '0;
            for (r = 0; r < NUM_ROUNDS; r++)
            begin
                y = y + (feistel_mix(z) ^ (sum + table_word(sum)));
                sum = sum + DELTA_STEP;
                z = z + (feistel_mix(y) ^ (sum + table_word(sum >> 11)));
            end
            res.cipher_low = y;
            res.cipher_high = z;
            return res;
        endfunction

        function void note_block(input word_t lo, input word_t hi);
            pending.push_back(encipher_block(lo, hi));
        endfunction

        function void check_cipher(input word_t lo, input word_t hi);
            cipher_pair_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected cipher request %h %h", $time, lo, hi);
            end
            else
            begin
                want = pending.pop_front();
                if (lo !== want.cipher_low)
                begin
                    errors++;
                    $display("%0t: cipher_low expected %h actual %h", $time,
                             want.cipher_low, lo);
                end
                if (hi !== want.cipher_high)
                begin
                    errors++;
                    $display("%0t: cipher_high expected %h actual %h", $time,
                             want.cipher_high, hi);
                end
            end
        endfunction

        function bit empty();
            return pending.size() == 0;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_WIDTH-1:0] paddr;
    logic [PDATA_WIDTH-1:0] pwdata;
    logic [PDATA_WIDTH-1:0] prdata;
    logic pready;

    xve_block_if plaintext_ch();
    xve_cipher_if cipher_ch();

    cipher_scoreboard scoreboard = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req = 1'b0;

    xtea_variant_block_encrypt #(
        .ROUND_COUNT(NUM_ROUNDS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .plaintext(plaintext_ch),
        .ciphertext(cipher_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function int pick_gap(input int pct);
        if (pct == 0 || $urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    function word_t rand_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task offer_block(input word_t lo, input word_t hi);
        int gap;
        plaintext_ch.valid <= 1'b1;
        plaintext_ch.block_low <= lo;
        plaintext_ch.block_high <= hi;
        @(posedge clk);
        while (!plaintext_ch.ready)
            @(posedge clk);
        scoreboard.note_block(lo, hi);
        gap = pick_gap(send_idle_pct);
        if (gap > 0)
        begin
            plaintext_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task drain_results();
        plaintext_ch.valid <= 1'b0;
        while (!scoreboard.empty())
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Writes the session key, then reads it back over the same port.
    task program_key(input word_t value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SESSION_KEY_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        scoreboard.session_key = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
        begin
            scoreboard.errors++;
            $display("%0t: session_key read expected %h actual %h", $time, value, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : result_sink
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        cipher_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cipher_ch.valid && cipher_ch.ready)
                scoreboard.check_cipher(cipher_ch.cipher_low, cipher_ch.cipher_high);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cipher_ch.ready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                cipher_ch.ready <= 1'b0;
            end
            else
            begin
                cipher_ch.ready <= 1'b1;
                idle_left = pick_gap(recv_idle_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((plaintext_ch.valid && plaintext_ch.ready) ||
                (cipher_ch.valid && cipher_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        word_t directed_low[10];
        word_t directed_high[10];
        word_t phase_key[NUM_PHASES];
        int phase_send_pct[NUM_PHASES];
        int phase_recv_pct[NUM_PHASES];
        int p;
        int i;

        directed_low = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                         32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h0000_0000,
                         32'h8000_0000, 32'h0123_4567};
        directed_high = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0001,
                          32'h8000_0000, 32'h89AB_CDEF};
        phase_key = '{32'hFFFF_FFFF, KEY_FIXED, 32'h0000_0001, 32'h8000_0000,
                      $urandom, $urandom, 32'h0000_0000};
        phase_send_pct = '{0, 25, 50, 10, 0, 35, 15};
        phase_recv_pct = '{0, 25, 10, 50, 0, 35, 15};

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        plaintext_ch.valid <= 1'b0;
        plaintext_ch.block_low <= '0;
        plaintext_ch.block_high <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The key comes out of reset as zero; the directed blocks run under it.
        for (i = 0; i < 10; i++)
            offer_block(directed_low[i], directed_high[i]);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            program_key(phase_key[p]);
            send_idle_pct = phase_send_pct[p];
            recv_idle_pct = phase_recv_pct[p];
            if (p == 4)
                hold_off_req = 1'b1;
            for (i = 0; i < BLOCKS_PER_PHASE; i++)
                offer_block(rand_word(), rand_word());
        end

        drain_results();
        if (scoreboard.errors == 0 && scoreboard.empty())
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/xve_pkg.sv
rtl/xve_block_if.sv
rtl/xve_apb_regs.sv
rtl/xve_round_cell.sv
rtl/xtea_variant_block_encrypt.sv
tb/sv/testbench.sv
